[src/tcon_pkg.sv]
package tcon_pkg;

  localparam int OP_W   = 2;
  localparam int CHAR_W = 8;
  localparam int ATTR_W = 8;
  localparam int ADDR_W = 11;
  localparam int CELL_W = CHAR_W + ATTR_W;

  localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
  localparam logic [OP_W-1:0] OP_READ  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'd10;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
  localparam logic [CHAR_W-1:0] CH_BLANK = 8'h20;

  localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h0F;

endpackage

[src/tcon_ram.sv]
module tcon_ram #(
  parameter int DEPTH = 2000,
  parameter int AW    = 11
) (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [AW-1:0]             wr_addr,
  input  logic [tcon_pkg::CELL_W-1:0] wr_data,
  input  logic                      rd_en,
  input  logic [AW-1:0]             rd_addr,
  output logic [tcon_pkg::CELL_W-1:0] rd_data
);
  import tcon_pkg::*;

  logic [CELL_W-1:0] mem [DEPTH];
  logic [CELL_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[src/text_console_put_char.sv]
// Text console: a COLUMNS x ROWS screen of 16-bit cells (character in the low byte,
// attribute in the high byte) kept in one simple dual-port RAM (one write and one
// registered read per cycle), plus a cursor. Opcode 0 puts a character (newline,
// return and tab move the cursor; other bytes are stored with the configured
// attribute), opcode 1 reads a cell, opcode 2 blanks the screen and homes the cursor.
// Every word in gives exactly one result word out. The block takes one word at a
// time and holds in_stall high while it works; a sequencer walks the RAM cell by
// cell for a scroll and a clear. After reset a clearing pass writes every cell with
// a space in attribute 0x0F, during which no word is taken (attribute writes on the
// cfg port are taken at any time). A finished result waits in the output register
// while the next word is accepted.
module text_console_put_char #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // configuration
  input  logic                        cfg_we,
  input  logic [tcon_pkg::ATTR_W-1:0] cfg_data,
  // input channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [tcon_pkg::OP_W-1:0]   in_opcode,
  input  logic [tcon_pkg::CHAR_W-1:0] in_character,
  input  logic [tcon_pkg::ADDR_W-1:0] in_cell_address,
  // result channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [tcon_pkg::ADDR_W-1:0] out_cursor_position,
  output logic [tcon_pkg::CHAR_W-1:0] out_read_character,
  output logic [tcon_pkg::ATTR_W-1:0] out_read_attribute,
  output logic                        out_scrolled
);
  import tcon_pkg::*;

  localparam int CELLS = COLUMNS * ROWS;
  localparam int COPY  = CELLS - COLUMNS;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(COLUMNS);
  localparam int RW    = $clog2(ROWS);
  localparam int PW    = (AW > ADDR_W) ? AW : ADDR_W;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_READ   = 3'd1;
  localparam logic [2:0] S_SCROLL = 3'd2;
  localparam logic [2:0] S_FILL   = 3'd3;
  localparam logic [2:0] S_DONE   = 3'd4;

  logic [2:0]        state_r, state_nxt;
  logic [AW-1:0]     cnt_r, cnt_nxt;
  logic              wpend_r, wpend_nxt;
  logic [AW-1:0]     wadr_r, wadr_nxt;
  logic              init_r, init_nxt;
  logic [ATTR_W-1:0] fill_attr_r, fill_attr_nxt;
  logic [ATTR_W-1:0] attr_r;
  logic [CW-1:0]     col_r, col_nxt;
  logic [RW-1:0]     row_r, row_nxt;

  logic              res_scrolled_r, res_scrolled_nxt;
  logic [CHAR_W-1:0] res_ch_r, res_ch_nxt;
  logic [ATTR_W-1:0] res_attr_r, res_attr_nxt;

  logic              out_valid_r;
  logic [ADDR_W-1:0] out_pos_r;
  logic [CHAR_W-1:0] out_ch_r;
  logic [ATTR_W-1:0] out_attr_r;
  logic              out_scrolled_r;

  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [CELL_W-1:0] wr_data;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic [CELL_W-1:0] rd_data;

  logic              accept;
  logic              out_free;
  logic              out_load;
  logic [AW-1:0]     cur_addr;
  logic [PW-1:0]     cur_pos_wide;
  logic [CW:0]       col_calc;
  logic [RW:0]       row_calc;
  logic              put_store;
  logic              need_scroll;
  logic              rd_in_range;

  tcon_ram #(
    .DEPTH (CELLS),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign out_load = (state_r == S_DONE) && out_free;

  assign cur_addr     = AW'(row_r * COLUMNS) + AW'(col_r);
  assign cur_pos_wide = PW'(cur_addr);
  assign rd_in_range  = (32'(in_cell_address) < 32'(CELLS));

  // Cursor math for a put: move, then wrap at the right edge, then clamp at the bottom.
  always_comb begin
    col_calc  = {1'b0, col_r};
    row_calc  = {1'b0, row_r};
    put_store = 1'b0;
    case (in_character)
      CH_LF: begin
        col_calc = '0;
        row_calc = {1'b0, row_r} + 1'b1;
      end
      CH_CR: begin
        col_calc = '0;
      end
      CH_TAB: begin
        col_calc = ({1'b0, col_r} + (CW + 1)'(8)) & ~(CW + 1)'(7);
      end
      default: begin
        col_calc  = {1'b0, col_r} + 1'b1;
        put_store = 1'b1;
      end
    endcase
    if (col_calc >= (CW + 1)'(COLUMNS)) begin
      col_calc = '0;
      row_calc = row_calc + 1'b1;
    end
    need_scroll = (row_calc >= (RW + 1)'(ROWS));
    if (need_scroll) begin
      row_calc = (RW + 1)'(ROWS - 1);
    end
  end

  // RAM port steering: accept writes the put character or launches the read, the
  // scroll copies one cell per cycle one row up, the fill blanks one cell per cycle.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cur_addr;
    wr_data = {attr_r, in_character};
    rd_en   = 1'b0;
    rd_addr = AW'(in_cell_address);
    case (state_r)
      S_IDLE: begin
        if (accept && in_opcode == OP_PUT && put_store) begin
          wr_en = 1'b1;
        end
        if (accept && in_opcode == OP_READ && rd_in_range) begin
          rd_en = 1'b1;
        end
      end
      S_SCROLL: begin
        if (wpend_r) begin
          wr_en   = 1'b1;
          wr_addr = wadr_r;
          wr_data = rd_data;
        end
        if (cnt_r != AW'(COPY)) begin
          rd_en   = 1'b1;
          rd_addr = cnt_r + AW'(COLUMNS);
        end
      end
      S_FILL: begin
        wr_en   = 1'b1;
        wr_addr = cnt_r;
        wr_data = {fill_attr_r, CH_BLANK};
      end
      default: begin
      end
    endcase
  end

  // Sequencer.
  always_comb begin
    state_nxt        = state_r;
    cnt_nxt          = cnt_r;
    wpend_nxt        = wpend_r;
    wadr_nxt         = wadr_r;
    init_nxt         = init_r;
    fill_attr_nxt    = fill_attr_r;
    col_nxt          = col_r;
    row_nxt          = row_r;
    res_scrolled_nxt = res_scrolled_r;
    res_ch_nxt       = res_ch_r;
    res_attr_nxt     = res_attr_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          res_scrolled_nxt = 1'b0;
          res_ch_nxt       = '0;
          res_attr_nxt     = '0;
          fill_attr_nxt    = attr_r;
          cnt_nxt          = '0;
          wpend_nxt        = 1'b0;
          state_nxt        = S_DONE;
          case (in_opcode)
            OP_PUT: begin
              col_nxt = CW'(col_calc);
              row_nxt = RW'(row_calc);
              if (need_scroll) begin
                res_scrolled_nxt = 1'b1;
                state_nxt        = S_SCROLL;
              end
            end
            OP_READ: begin
              if (rd_in_range) begin
                state_nxt = S_READ;
              end
            end
            OP_CLEAR: begin
              col_nxt   = '0;
              row_nxt   = '0;
              state_nxt = S_FILL;
            end
            default: begin
            end
          endcase
        end
      end
      S_READ: begin
        res_ch_nxt   = rd_data[CHAR_W-1:0];
        res_attr_nxt = rd_data[CELL_W-1:CHAR_W];
        state_nxt    = S_DONE;
      end
      S_SCROLL: begin
        // Advance the copy; the last pending write goes out as the fill starts.
        if (cnt_r == AW'(COPY)) begin
          wpend_nxt = 1'b0;
          state_nxt = S_FILL;
        end else begin
          wpend_nxt = 1'b1;
          wadr_nxt  = cnt_r;
          cnt_nxt   = cnt_r + 1'b1;
        end
      end
      S_FILL: begin
        if (cnt_r == AW'(CELLS - 1)) begin
          state_nxt = init_r ? S_IDLE : S_DONE;
          init_nxt  = 1'b0;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      // Start with the clearing pass in the reset attribute.
      state_r     <= S_FILL;
      cnt_r       <= '0;
      wpend_r     <= 1'b0;
      init_r      <= 1'b1;
      fill_attr_r <= RESET_ATTR;
      attr_r      <= RESET_ATTR;
      col_r       <= '0;
      row_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      wpend_r     <= wpend_nxt;
      init_r      <= init_nxt;
      fill_attr_r <= fill_attr_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      if (cfg_we) begin
        attr_r <= cfg_data;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers: no reset needed.
  always_ff @(posedge clk) begin
    wadr_r         <= wadr_nxt;
    res_scrolled_r <= res_scrolled_nxt;
    res_ch_r       <= res_ch_nxt;
    res_attr_r     <= res_attr_nxt;
    if (out_load) begin
      out_pos_r      <= cur_pos_wide[ADDR_W-1:0];
      out_ch_r       <= res_ch_r;
      out_attr_r     <= res_attr_r;
      out_scrolled_r <= res_scrolled_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_cursor_position = out_pos_r;
  assign out_read_character  = out_ch_r;
  assign out_read_attribute  = out_attr_r;
  assign out_scrolled        = out_scrolled_r;

endmodule

[tb/sv/tb_text_console_put_char.sv]
`timescale 1ns / 100ps

module tb_text_console_put_char;
  import tcon_pkg::*;

  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = COLUMNS * ROWS;

  // The package names the three live opcodes; the fourth is a no-op.
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  // Longest no-handshake stretch of a correct run is a scroll or the clearing
  // pass after reset overlapping the long receiver hold-off and a long sender
  // gap. Allow several times that.
  localparam int IDLE_LIMIT   = 20000;
  localparam int HOLD_AFTER   = 300;  // results seen before the long hold-off
  localparam int HOLD_CYCLES  = 500;
  localparam int DRAIN_CYCLES = 50;
  localparam int PHASE_WORDS  = 300;
  localparam int PHASES       = 5;

  // Mirror of the console: screen, cursor and attribute register, plus the
  // queue of reports still owed by the block.
  class console_mirror #(int COLS = 80, int LINES = 25);
    typedef struct packed {
      logic [ADDR_W-1:0] cursor_position;
      logic [CHAR_W-1:0] read_character;
      logic [ATTR_W-1:0] read_attribute;
      logic              scrolled;
    } console_report_t;

    logic [CELL_W-1:0] screen [COLS*LINES];
    int                col;
    int                row;
    logic [ATTR_W-1:0] attr;
    console_report_t   pending_reports[$];
    int                errors;
    int                checked;

    function new();
      foreach (screen[i]) screen[i] = {RESET_ATTR, CH_BLANK};
      col     = 0;
      row     = 0;
      attr    = RESET_ATTR;
      errors  = 0;
      checked = 0;
    endfunction

    // Advance the mirror by one accepted word and queue the report it owes.
    function void note_word(logic [OP_W-1:0] op, logic [CHAR_W-1:0] ch,
                            logic [ADDR_W-1:0] addr);
      console_report_t rep;
      int i;
      rep = '0;
      case (op)
        OP_PUT: begin
          if (ch == CH_LF) begin
            col = 0;
            row++;
          end else if (ch == CH_CR) begin
            col = 0;
          end else if (ch == CH_TAB) begin
            col = (col + 8) & ~7;
          end else begin
            screen[row*COLS + col] = {attr, ch};
            col++;
          end
          if (col >= COLS) begin
            col = 0;
            row++;
          end
          if (row >= LINES) begin
            for (i = 0; i < COLS*(LINES-1); i++) screen[i] = screen[i+COLS];
            for (i = COLS*(LINES-1); i < COLS*LINES; i++) screen[i] = {attr, CH_BLANK};
            row = LINES - 1;
            rep.scrolled = 1'b1;
          end
        end
        OP_READ: begin
          if (addr < COLS*LINES) {rep.read_attribute, rep.read_character} = screen[addr];
        end
        OP_CLEAR: begin
          foreach (screen[i]) screen[i] = {attr, CH_BLANK};
          col = 0;
          row = 0;
        end
        default: ;
      endcase
      rep.cursor_position = ADDR_W'(row*COLS + col);
      pending_reports.push_back(rep);
    endfunction

    task report(string what, int got, int want);
      $display("ERROR: result %0d %s: got %0d expected %0d", checked, what, got, want);
      errors++;
    endtask

    task check_report(logic [ADDR_W-1:0] pos, logic [CHAR_W-1:0] rd_ch,
                      logic [ATTR_W-1:0] rd_attr, logic scr);
      console_report_t want;
      if (pending_reports.size() == 0) begin
        report("with no word pending, cursor_position", int'(pos), 0);
      end else begin
        want = pending_reports.pop_front();
        if (pos !== want.cursor_position)
          report("cursor_position", int'(pos), int'(want.cursor_position));
        if (rd_ch !== want.read_character)
          report("read_character", int'(rd_ch), int'(want.read_character));
        if (rd_attr !== want.read_attribute)
          report("read_attribute", int'(rd_attr), int'(want.read_attribute));
        if (scr !== want.scrolled)
          report("scrolled", int'(scr), int'(want.scrolled));
      end
      checked++;
    endtask
  endclass

  logic              clk             = 1'b0;
  logic              rst_n           = 1'b0;
  logic              cfg_we          = 1'b0;
  logic [ATTR_W-1:0] cfg_data        = RESET_ATTR;
  logic              in_valid        = 1'b0;
  logic              in_stall;
  logic [OP_W-1:0]   in_opcode       = OP_PUT;
  logic [CHAR_W-1:0] in_character    = CH_BLANK;
  logic [ADDR_W-1:0] in_cell_address = '0;
  logic              out_valid;
  logic              out_stall       = 1'b0;
  logic [ADDR_W-1:0] out_cursor_position;
  logic [CHAR_W-1:0] out_read_character;
  logic [ATTR_W-1:0] out_read_attribute;
  logic              out_scrolled;

  console_mirror #(COLUMNS, ROWS) mirror;

  int results_taken = 0;
  int quiet_cycles  = 0;
  bit steady        = 1'b0;  // when set, neither side idles

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  text_console_put_char #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_data            (cfg_data),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_opcode           (in_opcode),
    .in_character        (in_character),
    .in_cell_address     (in_cell_address),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_cursor_position (out_cursor_position),
    .out_read_character  (out_read_character),
    .out_read_attribute  (out_read_attribute),
    .out_scrolled        (out_scrolled)
  );

  // Offer one word after a random gap and hold it until the block takes it.
  // Valid stays high after the handshake; the next call either replaces the
  // payload at the following falling edge or drops valid for the gap.
  task automatic send_word(input logic [OP_W-1:0] op, input logic [CHAR_W-1:0] ch,
                           input logic [ADDR_W-1:0] addr);
    int gap;
    int pick;
    pick = $urandom_range(0, 19);
    if (steady || pick < 12) gap = 0;
    else if (pick < 18) gap = $urandom_range(1, 3);
    else gap = $urandom_range(8, 40);
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_opcode       <= op;
    in_character    <= ch;
    in_cell_address <= addr;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    mirror.note_word(op, ch, addr);
  endtask

  // Drop valid, let every owed report come back, then write the attribute.
  // Every word yields a report, so an empty queue means the block is idle.
  task automatic set_attribute(input logic [ATTR_W-1:0] value);
    @(negedge clk);
    in_valid <= 1'b0;
    while (mirror.pending_reports.size() != 0) @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    mirror.attr = value;
  endtask

  // Mostly text with control bytes mixed in so the cursor walks down, wraps
  // and scrolls; reads favor cells just behind the cursor so they hit fresh
  // writes, with some anywhere and some past the end of the screen.
  task automatic random_word();
    int                pick;
    int                here;
    logic [ADDR_W-1:0] addr;
    logic [CHAR_W-1:0] ch;
    addr = ADDR_W'($urandom_range(0, 2**ADDR_W - 1));
    ch   = CHAR_W'($urandom_range(0, 255));
    pick = $urandom_range(0, 99);
    if ($urandom_range(0, 249) == 0) begin
      send_word(OP_CLEAR, ch, addr);
    end else if (pick < 50) begin
      send_word(OP_PUT, ch, addr);
    end else if (pick < 58) begin
      send_word(OP_PUT, CH_LF, addr);
    end else if (pick < 62) begin
      send_word(OP_PUT, CH_CR, addr);
    end else if (pick < 68) begin
      send_word(OP_PUT, CH_TAB, addr);
    end else if (pick < 95) begin
      here = mirror.row * COLUMNS + mirror.col;
      pick = $urandom_range(0, 9);
      if (pick < 6)
        addr = (here >= 160) ? ADDR_W'(here - int'($urandom_range(0, 160)))
                             : ADDR_W'($urandom_range(0, here));
      else if (pick < 9)
        addr = ADDR_W'($urandom_range(0, CELLS - 1));
      send_word(OP_READ, ch, addr);
    end else begin
      send_word(OP_UNUSED, ch, addr);
    end
  endtask

  // Receiver: random stall bursts, plus one long hold-off so the result
  // register stays full and the block has to stall its input.
  initial begin : receiver
    int len;
    int pick;
    bit held;
    held = 1'b0;
    forever begin
      if (!held && results_taken >= HOLD_AFTER) begin
        held = 1'b1;
        len  = HOLD_CYCLES;
      end else begin
        pick = $urandom_range(0, 19);
        if (steady || pick < 12) len = 0;
        else if (pick < 18) len = $urandom_range(1, 3);
        else len = $urandom_range(8, 40);
      end
      repeat (len) begin
        @(negedge clk);
        out_stall <= 1'b1;
      end
      repeat ($urandom_range(1, 12)) begin
        @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Check every accepted report against the oldest owed one.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      mirror.check_report(out_cursor_position, out_read_character,
                          out_read_attribute, out_scrolled);
      results_taken++;
    end
  end

  // Watchdog: count cycles with no handshake on either side.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("ERROR: no handshake for %0d cycles", IDLE_LIMIT);
        $display("text_console_put_char verification failed");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int            p;
    logic [ATTR_W-1:0] value;
    mirror = new();
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // Directed words at the reset attribute. The first reads also confirm
    // the clearing pass after reset left blanks in attribute 0x0F.
    send_word(OP_READ, 8'h00, 11'd0);
    send_word(OP_READ, 8'hFF, ADDR_W'(CELLS - 1));
    send_word(OP_READ, 8'h00, ADDR_W'(CELLS));      // first address off the screen
    send_word(OP_READ, 8'hFF, 11'h7FF);             // address all ones
    send_word(OP_PUT, 8'h00, 11'h7FF);
    send_word(OP_PUT, 8'hFF, 11'd0);
    send_word(OP_PUT, CH_TAB, 11'd0);
    send_word(OP_PUT, 8'h41, 11'd0);
    send_word(OP_PUT, CH_CR, 11'd0);
    send_word(OP_PUT, 8'h5A, 11'd0);
    send_word(OP_PUT, CH_LF, 11'd0);
    send_word(OP_UNUSED, 8'hFF, 11'h7FF);
    send_word(OP_UNUSED, CH_LF, 11'd0);
    send_word(OP_READ, 8'h00, 11'd0);
    send_word(OP_READ, 8'h00, 11'd1);
    send_word(OP_READ, 8'h00, 11'd8);
    send_word(OP_CLEAR, 8'hFF, 11'h7FF);
    send_word(OP_READ, 8'h00, 11'd0);
    send_word(OP_READ, 8'h00, 11'd8);

    // Random phases, each at its own attribute; extremes first. The cursor
    // carries over from phase to phase so later phases scroll a lot.
    for (p = 0; p < PHASES; p++) begin
      case (p)
        0:       value = 8'h00;
        1:       value = 8'hFF;
        default: value = ATTR_W'($urandom_range(0, 255));
      endcase
      set_attribute(value);
      steady = (p == 2);
      repeat (PHASE_WORDS) random_word();
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (mirror.pending_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mirror.errors == 0) $display("text_console_put_char verification clean");
    else $display("text_console_put_char verification failed");
    $finish;
  end

endmodule

[files.f]
src/tcon_pkg.sv
src/tcon_ram.sv
src/text_console_put_char.sv
tb/sv/tb_text_console_put_char.sv
